// ----- rtl/pwmv_pkg.sv -----
// Package for the pixel weighted mean/variance unit: widths, queue entry type.
// No dependencies.
package pwmv_pkg;
    localparam int TABLE_DEPTH = 4096;
    localparam int PIXEL_COUNT = 65536;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ACC, S_SQ, S_DIVM, S_DIVV, S_OUT
    } t_state;

    // classified contribution waiting for the back end
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] weight;
        logic [15:0]        pixel;
        logic [15:0]        count;
        logic               last;
    } t_job;
endpackage

// ----- rtl/pixel_weighted_mean_variance_unit.sv -----
// Pixel weighted mean/variance unit: usage.
// Input channel (i_valid/o_ready) takes loads (action 0) and contributions
// (action 1). A load writes the sample table; a contribution is looked up
// and queued for the back end, which multiplies weight by sample value and
// accumulates sum and sum of squares with saturation.
// On a last contribution with a nonzero count and pixel in range one result
// (pixel, mean, variance) appears on o_valid/i_ready.
// Throughput: loads one per cycle while o_ready is high. A contribution holds
// the back end through S_MUL and S_ACC; a last contribution with a nonzero
// count holds it also through S_SQ, the bit-serial 128-bit divider run twice
// (mean, then variance) and S_OUT; one with a zero count also through S_SQ.
// A result passes lookup, queue, S_MUL, S_ACC, S_SQ, S_DIVM and S_DIVV.
// A four-entry queue parts lookup from the back end, so loads and lookups
// keep flowing while the back end works, until the queue fills.
// A stalled receiver holds the result and the back end; the queue then fills
// and o_ready falls. Reset clears sums, queue and control; the sample table
// is undefined until loaded.
// Depends on pwmv_pkg, pwmv_front, pwmv_back.
module pixel_weighted_mean_variance_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic [11:0]        i_point_index,
    input  logic signed [31:0] i_sample,
    input  logic signed [31:0] i_weight,
    input  logic [15:0]        i_pixel_index,
    input  logic [15:0]        i_point_count,
    input  logic               i_last_contribution,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_out_pixel,
    output logic signed [47:0] o_signal,
    output logic [62:0]        o_variance
);
    import pwmv_pkg::*;
    t_job job;
    logic jv, jr;

    pwmv_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_action, .i_point_index,
        .i_sample, .i_weight, .i_pixel_index, .i_point_count,
        .i_last_contribution, .o_job_valid(jv), .i_job_ready(jr), .o_job(job)
    );

    pwmv_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(jv), .o_job_ready(jr), .i_job(job),
        .o_valid, .i_ready, .o_out_pixel, .o_signal, .o_variance
    );
endmodule

// ----- rtl/pwmv_ram.sv -----
// Generic single-port-write, registered-read RAM.
// No dependencies.
module pwmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/pwmv_front.sv -----
// Front end: table loads, table lookup and the job queue.
// Depends on pwmv_pkg and pwmv_ram.
module pwmv_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic [11:0]        i_point_index,
    input  logic signed [31:0] i_sample,
    input  logic signed [31:0] i_weight,
    input  logic [15:0]        i_pixel_index,
    input  logic [15:0]        i_point_count,
    input  logic               i_last_contribution,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output pwmv_pkg::t_job     o_job
);
    import pwmv_pkg::*;

    logic            r_lv;      // lookup in flight
    t_job            r_lj;
    t_job            lk_job;
    logic            r_lin;     // index was inside the table
    logic [31:0]     rd;
    t_job            r_q [QDEPTH];
    logic [QAW-1:0]  r_wp, r_rp;
    logic [QAW:0]    r_cnt;
    logic            acc, push, pop, in_table;

    // reserve a slot for the lookup in flight
    assign o_ready = (r_cnt + {{QAW{1'b0}}, r_lv}) < (QAW+1)'(QDEPTH);
    assign acc = i_valid && o_ready;
    assign in_table = 32'(i_point_index) < TABLE_DEPTH;

    pwmv_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_tab (
        .i_clk(i_clk),
        .i_we(acc && !i_action && in_table),
        .i_waddr(i_point_index[AW-1:0]),
        .i_wdata(i_sample),
        .i_raddr(i_point_index[AW-1:0]),
        .o_rdata(rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lv <= 1'b0;
        else r_lv <= acc && i_action;
        r_lin <= in_table;
        r_lj.value  <= '0;
        r_lj.weight <= i_weight;
        r_lj.pixel  <= i_pixel_index;
        r_lj.count  <= i_point_count;
        r_lj.last   <= i_last_contribution;
    end

    // merge the table value into the captured job
    always_comb begin
        lk_job = r_lj;
        lk_job.value = r_lin ? rd : 32'sd0;
    end

    assign push = r_lv;
    assign pop  = o_job_valid && i_job_ready;
    assign o_job_valid = r_cnt != '0;
    assign o_job = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= lk_job;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
        end
    end
endmodule

// ----- rtl/pwmv_divider.sv -----
// Bit-serial unsigned divider, one quotient bit per cycle.
// Depends on pwmv_pkg.
module pwmv_divider (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_num,
    input  logic [31:0]  i_den,
    output logic         o_done,
    output logic [127:0] o_quo
);
    import pwmv_pkg::*;
    logic [127:0] r_q;
    logic [32:0]  r_rem;
    logic [31:0]  r_d;
    logic [7:0]   r_n;
    logic         r_busy;
    logic [32:0]  t;

    assign t = {r_rem[31:0], r_q[127]};
    assign o_quo = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1; r_n <= 8'd128;
                r_q <= i_num; r_rem <= '0; r_d <= i_den;
            end else if (r_busy) begin
                if (t >= {1'b0, r_d}) begin
                    r_rem <= t - {1'b0, r_d};
                    r_q <= {r_q[126:0], 1'b1};
                end else begin
                    r_rem <= t;
                    r_q <= {r_q[126:0], 1'b0};
                end
                r_n <= r_n - 1'b1;
                if (r_n == 8'd1) begin
                    r_busy <= 1'b0; o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- rtl/pwmv_back.sv -----
// Back end: multiply-accumulate, end-of-pixel mean and variance.
// Depends on pwmv_pkg and pwmv_divider.
module pwmv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_ready,
    input  pwmv_pkg::t_job     i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_out_pixel,
    output logic signed [47:0] o_signal,
    output logic [62:0]        o_variance
);
    import pwmv_pkg::*;

    t_state r_st, n_st;
    t_job   r_j;
    logic signed [63:0]  r_prod64;
    logic signed [31:0]  r_prod;
    logic signed [47:0]  r_sum, r_s;
    logic [63:0]         r_ss, r_sss;
    logic [47:0]         r_mag;
    logic [95:0]         r_sq;
    logic [1:0]          r_sq_step;
    logic                r_sq_part;
    logic                r_neg;
    logic signed [47:0]  r_mean;

    logic         d_start, d_done;
    logic [127:0] d_num, d_quo, sq_diff;
    logic [31:0]  d_den;

    logic signed [47:0] fl;
    logic signed [48:0] nsum;
    logic signed [47:0] sat_sum;
    logic [64:0]        nss;
    logic [63:0]        sat_ss;
    logic [63:0]        psq;
    logic [23:0]        sq_a, sq_b;
    logic [47:0]        sq_pp;
    logic [95:0]        sq_term;

    pwmv_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
        .i_num(d_num), .i_den(d_den), .o_done(d_done), .o_quo(d_quo)
    );

    assign fl   = 48'(r_prod64 >>> 16);
    assign nsum = 49'(r_sum) + 49'(r_prod);
    assign psq  = 64'(r_prod * r_prod);
    assign nss  = {1'b0, r_ss} + {1'b0, psq};
    assign sat_sum = (nsum > 49'sh7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                     (nsum < -49'sh8000_0000_0000) ? 48'sh8000_0000_0000 : 48'(nsum);
    assign sat_ss = nss[64] ? '1 : nss[63:0];

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_job_valid) n_st = S_MUL;
            S_MUL:  n_st = S_ACC;
            S_ACC:  n_st = r_j.last ? S_SQ : S_IDLE;
            S_SQ:   if (r_sq_part) n_st = (r_j.count == '0 ||
                        32'(r_j.pixel) >= PIXEL_COUNT) ? S_IDLE : S_DIVM;
            S_DIVM: if (d_done) n_st = S_DIVV;
            S_DIVV: if (d_done) n_st = S_OUT;
            S_OUT:  if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready = r_st == S_IDLE;
        o_valid = r_st == S_OUT;
        d_start = 1'b0;
        d_num = {80'd0, r_mag};
        d_den = {16'd0, r_j.count};
        if (r_st == S_SQ && r_sq_part && r_j.count != '0) d_start = 1'b1;
        if (r_st == S_DIVM && d_done) begin
            d_start = 1'b1;
            d_num = sq_diff;
            d_den = 32'(r_j.count) * 32'(r_j.count);
        end
    end

    // square the magnitude from 24-bit halves: low*low, 2*low*high, high*high
    always_comb begin
        sq_a = r_mag[23:0];
        sq_b = r_mag[23:0];
        if (r_sq_step == 2'd1) begin
            sq_b = r_mag[47:24];
        end else if (r_sq_step == 2'd2) begin
            sq_a = r_mag[47:24];
            sq_b = r_mag[47:24];
        end
    end

    assign sq_pp = sq_a * sq_b;

    always_comb begin
        unique case (r_sq_step)
            2'd0: sq_term = 96'(sq_pp);
            2'd1: sq_term = 96'(sq_pp) << 25;
            2'd2: sq_term = 96'(sq_pp) << 48;
            2'd3: sq_term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_sum <= '0; r_ss <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == S_ACC) begin
                if (r_j.last) begin
                    r_sum <= '0; r_ss <= '0;
                end else begin
                    r_sum <= sat_sum; r_ss <= sat_ss;
                end
            end
        end
        if (r_st == S_IDLE && i_job_valid) r_j <= i_job;
        if (r_st == S_IDLE) r_prod64 <= 64'(i_job.weight) * 64'(i_job.value);
        if (r_st == S_MUL) begin
            if (fl > 48'sh7FFF_FFFF) r_prod <= 32'sh7FFF_FFFF;
            else if (fl < -48'sh8000_0000) r_prod <= 32'sh8000_0000;
            else r_prod <= 32'(fl);
        end
        if (r_st == S_ACC) begin
            r_s <= sat_sum;
            r_sss <= sat_ss;
            r_sq_part <= 1'b0;
        end
        if (r_st == S_SQ) begin
            if (!r_sq_part) begin
                r_neg <= r_s[47];
                r_mag <= r_s[47] ? 48'(-r_s) : 48'(r_s);
                r_sq_part <= 1'b1;
                r_sq <= '0;
                r_sq_step <= '0;
            end
        end
        // build the square while the mean divide runs
        if (r_st == S_DIVM && !d_done && r_sq_step != 2'd3) begin
            r_sq <= r_sq + sq_term;
            r_sq_step <= r_sq_step + 2'd1;
        end
        if (r_st == S_DIVM && d_done) begin
            r_mean <= r_neg ? -48'(d_quo) : 48'(d_quo);
        end
        if (r_st == S_DIVV && d_done) begin
            o_out_pixel <= r_j.pixel;
            o_signal <= r_mean;
            o_variance <= (d_quo[127:63] != '0) ? {63{1'b1}} : d_quo[62:0];
        end
    end

    // |sum^2 - sumsq| for the variance divide
    always_comb begin
        if (r_sq >= 96'(r_sss)) sq_diff = 128'(r_sq - 96'(r_sss));
        else sq_diff = 128'(96'(r_sss) - r_sq);
    end
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Testbench for pixel_weighted_mean_variance_unit: loads, contributions, per-pixel results,
// checked against a cycle-free predictor. Depends on pwmv_pkg and the unit's RTL only.
module tb;
    import pwmv_pkg::*;

    localparam longint SUM_HI = 64'sd140737488355327;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam logic [62:0] VAR_TOP = {63{1'b1}};
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 600;
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_CONTRIB = 1'b1;

    typedef struct {
        logic [15:0]        pixel;
        logic signed [47:0] mean;
        logic [62:0]        spread;
    } t_pixel_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_action = 1'b0;
    logic [11:0]        i_point_index = '0;
    logic signed [31:0] i_sample = '0;
    logic signed [31:0] i_weight = '0;
    logic [15:0]        i_pixel_index = '0;
    logic [15:0]        i_point_count = '0;
    logic               i_last_contribution = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [15:0]        o_out_pixel;
    logic signed [47:0] o_signal;
    logic [62:0]        o_variance;

    // predictor state
    logic [31:0]   sample_mem [TABLE_DEPTH];
    int            loaded_idx [$];
    bit            is_loaded [TABLE_DEPTH];
    longint        acc_sum;
    logic [63:0]   acc_sumsq;
    t_pixel_result pending_results [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req = 1'b0;
    int hold_cnt = 0;
    bit tx_fire, rx_fire;
    t_pixel_result rx_seen;
    int errors = 0;
    int results_checked = 0;
    int items_sent = 0;
    int idle_cycles = 0;

    pixel_weighted_mean_variance_unit DUT (.*);

    always #5 i_clk = ~i_clk;

    // sample both handshakes mid-cycle; the transfer happens at the next rising edge
    always @(negedge i_clk) begin
        tx_fire = i_valid && o_ready;
        rx_fire = o_valid && i_ready;
        rx_seen.pixel = o_out_pixel;
        rx_seen.mean = o_signal;
        rx_seen.spread = o_variance;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_pixel_result exp_r;
        if (i_rst_n && rx_fire) begin
            if (pending_results.size() == 0) begin
                $error("result for pixel %0d with no expectation", rx_seen.pixel);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                results_checked++;
                if (rx_seen.pixel !== exp_r.pixel) begin
                    $error("out_pixel: expected %0d, got %0d", exp_r.pixel, rx_seen.pixel);
                    errors++;
                end
                if (rx_seen.mean !== exp_r.mean) begin
                    $error("signal: expected %0d, got %0d", exp_r.mean, rx_seen.mean);
                    errors++;
                end
                if (rx_seen.spread !== exp_r.spread) begin
                    $error("variance: expected %0d, got %0d", exp_r.spread, rx_seen.spread);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || tx_fire || rx_fire) begin
            idle_cycles = 0;
        end else if (++idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // fold one accepted item into the predicted sums; queue a result on a closing item
    task automatic accumulate_item(input logic act, input logic [11:0] idx,
                                   input logic signed [31:0] smp, input logic signed [31:0] w,
                                   input logic [15:0] pix, input logic [15:0] cnt,
                                   input logic last);
        longint        prod;
        logic [64:0]   sq_total;
        logic [127:0]  mag, diff, quot, ss;
        t_pixel_result r;
        if (act == ACT_LOAD) begin
            sample_mem[idx] = smp;
            if (!is_loaded[idx]) loaded_idx.push_back(int'(idx));
            is_loaded[idx] = 1'b1;
            return;
        end
        prod = (longint'(w) * longint'($signed(sample_mem[idx]))) >>> 16;
        if (prod > 64'sd2147483647) prod = 64'sd2147483647;
        if (prod < -64'sd2147483648) prod = -64'sd2147483648;
        acc_sum = acc_sum + prod;
        if (acc_sum > SUM_HI) acc_sum = SUM_HI;
        if (acc_sum < SUM_LO) acc_sum = SUM_LO;
        sq_total = {1'b0, acc_sumsq} + 65'(prod * prod);
        acc_sumsq = sq_total[64] ? '1 : sq_total[63:0];
        if (!last) return;
        if (cnt != 0) begin
            mag = (acc_sum < 0) ? 128'(-acc_sum) : 128'(acc_sum);
            mag = mag * mag;
            ss = 128'(acc_sumsq);
            diff = (mag >= ss) ? mag - ss : ss - mag;
            quot = diff / (128'(cnt) * 128'(cnt));
            r.pixel = pix;
            r.mean = 48'(acc_sum / longint'({48'd0, cnt}));
            r.spread = (quot > 128'(VAR_TOP)) ? VAR_TOP : quot[62:0];
            pending_results.push_back(r);
        end
        acc_sum = 0;
        acc_sumsq = '0;
    endtask

    // called at a rising edge; returns at the rising edge of the transfer
    task automatic send_item(input logic act, input logic [11:0] idx,
                             input logic signed [31:0] smp, input logic signed [31:0] w,
                             input logic [15:0] pix, input logic [15:0] cnt,
                             input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_point_index <= idx;
        i_sample <= smp;
        i_weight <= w;
        i_pixel_index <= pix;
        i_point_count <= cnt;
        i_last_contribution <= last;
        do @(posedge i_clk); while (!tx_fire);
        accumulate_item(act, idx, smp, w, pix, cnt, last);
        items_sent++;
    endtask

    task automatic send_load(input logic [11:0] idx, input logic signed [31:0] smp);
        // ignored fields carry noise
        send_item(ACT_LOAD, idx, smp, $urandom, 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic send_contrib(input logic [11:0] idx, input logic signed [31:0] w,
                                input logic [15:0] pix, input logic [15:0] cnt,
                                input logic last);
        send_item(ACT_CONTRIB, idx, $urandom, w, pix, cnt, last);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_load(12'd0, 32'sh7FFF_FFFF);
        send_load(12'd4095, 32'sh8000_0000);
        send_load(12'd1, 32'sh0001_0000);
        send_load(12'd2, -32'sh0001_0000);
        // positive and negative product saturation
        send_contrib(12'd0, 32'sh7FFF_FFFF, 16'd0, 16'd1, 1'b1);
        send_contrib(12'd0, 32'sh8000_0000, 16'd1, 16'd2, 1'b1);
        // min times min, then pile up squares until the square sum saturates
        repeat (5) send_contrib(12'd4095, 32'sh8000_0000, 16'd7, 16'd3, 1'b0);
        send_contrib(12'd4095, 32'sh8000_0000, 16'd65535, 16'd1, 1'b1);
        // zero count adds, clears and emits nothing
        send_contrib(12'd1, 32'sh0003_0000, 16'd9, 16'd4, 1'b0);
        send_contrib(12'd2, 32'sh0005_0000, 16'd9, 16'd0, 1'b1);
        send_contrib(12'd1, 32'sh0000_0000, 16'd10, 16'd65535, 1'b1);
        send_contrib(12'd2, 32'sh0002_8000, 16'd11, 16'd2, 1'b0);
        send_contrib(12'd1, -32'sh0001_4000, 16'd11, 16'd2, 1'b1);
        send_contrib(12'd4095, 32'sh0000_0001, 16'hFFFF, 16'hFFFF, 1'b1);
        drain_results();
    endtask

    task automatic test_random(input int n_items, input int tx_pct, input int rx_pct);
        logic [15:0] cnt;
        int sel;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n_items) begin
            if ($urandom_range(99) < 20 || loaded_idx.size() == 0) begin
                send_load(12'($urandom_range(4095)), $urandom);
            end else begin
                sel = $urandom_range(9);
                cnt = (sel < 7) ? 16'($urandom_range(1, 8)) : (sel == 7) ? 16'd0 : 16'($urandom);
                send_contrib(12'(loaded_idx[$urandom_range(loaded_idx.size() - 1)]),
                             ($urandom_range(3) == 0) ? $urandom : $signed($urandom) >>> 12,
                             16'($urandom), cnt, $urandom_range(5) == 0);
            end
        end
        // close any open pixel so every phase ends with clear sums
        send_contrib(12'(loaded_idx[0]), $urandom, 16'($urandom), 16'd1, 1'b1);
        drain_results();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(negedge i_clk) hold_req = 1'b1;
        @(posedge i_clk);
        repeat (40) send_contrib(12'(loaded_idx[$urandom_range(loaded_idx.size() - 1)]),
                                 $signed($urandom) >>> 8, 16'($urandom), 16'd3, 1'b1);
        drain_results();
    endtask

    initial begin
        acc_sum = 0;
        acc_sumsq = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(215, 8, 66);
        test_random(215, 66, 8);
        test_random(215, 0, 0);
        test_backpressure();
        $display("Sent %0d items (loads, contributions, saturating and zero-count cases);",
                 items_sent);
        $display("checked %0d pixel results under random idling and a long receiver hold.",
                 results_checked);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
